@@ rtl/segx_pkg.sv @@
// ----------------------------------------------------------------------------
// segx_pkg
// Shared constants for the segment intersection pipeline.
// ----------------------------------------------------------------------------
package segx_pkg;

    localparam int COORD_BITS_DEF = 16;  // coordinate width taken from each field
    localparam int FRAC_BITS_DEF  = 16;  // fraction bits of t and of the point
    localparam int IN_W           = 16;  // width of one input coordinate port
    localparam int PT_W           = 32;  // width of one point coordinate port
    localparam int NUM_COORDS     = 8;

endpackage

@@ rtl/segment_intersection.sv @@
// ----------------------------------------------------------------------------
// segment_intersection
// Exact 2D segment intersection: cross products, range test, Q1.F t and
// the intersection point in fixed point.
// ----------------------------------------------------------------------------
//  channel   | signals                                   | flow
//  ----------+-------------------------------------------+--------------------
//  command   | start, busy, seg_a_*/seg_b_* coordinates  | word taken on start
//  result    | done, hit, parallel, param_along_a,       | one word per
//            | point_x, point_y                          | command, no stall
//
//  Five stages of differences, products, cross sums, sign fold and range
//  test, then one divider stage per quotient bit, then the point multiply
//  and add.
//  A new word is taken every cycle; busy stays low.
//  Reset clears only the valid bits; words in flight are dropped.
// ----------------------------------------------------------------------------
module segment_intersection
    import segx_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [IN_W-1:0]   seg_a_start_x,
    input  logic signed [IN_W-1:0]   seg_a_start_y,
    input  logic signed [IN_W-1:0]   seg_a_end_x,
    input  logic signed [IN_W-1:0]   seg_a_end_y,
    input  logic signed [IN_W-1:0]   seg_b_start_x,
    input  logic signed [IN_W-1:0]   seg_b_start_y,
    input  logic signed [IN_W-1:0]   seg_b_end_x,
    input  logic signed [IN_W-1:0]   seg_b_end_y,
    output logic                     done,
    output logic                     hit,
    output logic                     parallel,
    output logic [FRAC_BITS:0]       param_along_a,
    output logic signed [PT_W-1:0]   point_x,
    output logic signed [PT_W-1:0]   point_y
);

    localparam int CB     = COORD_BITS;
    localparam int DW     = CB + 1;             // difference width
    localparam int PW     = 2 * DW;             // product width
    localparam int XW     = PW + 1;             // cross product width
    localparam int NW     = 2 * CB + 2;         // cross magnitude width
    localparam int TW     = FRAC_BITS + 1;      // quotient width
    localparam int SW     = CB + FRAC_BITS + 3; // point sum width
    localparam int SIDE_W = 2 * DW + 2 * CB + 2;

    assign busy = 1'b0;

    // ---- coordinate extraction ----
    logic [IN_W-1:0]     raw [0:NUM_COORDS-1];
    logic signed [CB-1:0] crd [0:NUM_COORDS-1];

    assign raw[0] = seg_a_start_x;
    assign raw[1] = seg_a_start_y;
    assign raw[2] = seg_a_end_x;
    assign raw[3] = seg_a_end_y;
    assign raw[4] = seg_b_start_x;
    assign raw[5] = seg_b_start_y;
    assign raw[6] = seg_b_end_x;
    assign raw[7] = seg_b_end_y;

    for (genvar i = 0; i < NUM_COORDS; i++)
    begin : g_crd
        if (CB <= IN_W)
        begin : g_narrow
            assign crd[i] = raw[i][CB-1:0];
        end
        else
        begin : g_wide
            // a wider coordinate than the port holds reads as non-negative
            assign crd[i] = {{(CB-IN_W){1'b0}}, raw[i]};
        end
    end

    // ---- stage 1: differences ----
    logic                 v1_reg;
    logic signed [DW-1:0] dax1_reg, day1_reg, dbx1_reg, dby1_reg, ex1_reg, ey1_reg;
    logic signed [CB-1:0] ax1_reg, ay1_reg;

    always_ff @(posedge clk)
    begin
        dax1_reg <= DW'(crd[2]) - DW'(crd[0]);
        day1_reg <= DW'(crd[3]) - DW'(crd[1]);
        dbx1_reg <= DW'(crd[6]) - DW'(crd[4]);
        dby1_reg <= DW'(crd[7]) - DW'(crd[5]);
        ex1_reg  <= DW'(crd[4]) - DW'(crd[0]);
        ey1_reg  <= DW'(crd[5]) - DW'(crd[1]);
        ax1_reg  <= crd[0];
        ay1_reg  <= crd[1];
    end

    // ---- stage 2: products ----
    logic                 v2_reg;
    logic signed [PW-1:0] p_adb_reg, p_adbx_reg, p_edb_reg, p_edbx_reg, p_eda_reg, p_edax_reg;
    logic signed [DW-1:0] dax2_reg, day2_reg;
    logic signed [CB-1:0] ax2_reg, ay2_reg;

    always_ff @(posedge clk)
    begin
        p_adb_reg  <= PW'(dax1_reg) * PW'(dby1_reg);
        p_adbx_reg <= PW'(day1_reg) * PW'(dbx1_reg);
        p_edb_reg  <= PW'(ex1_reg) * PW'(dby1_reg);
        p_edbx_reg <= PW'(ey1_reg) * PW'(dbx1_reg);
        p_eda_reg  <= PW'(ex1_reg) * PW'(day1_reg);
        p_edax_reg <= PW'(ey1_reg) * PW'(dax1_reg);
        dax2_reg   <= dax1_reg;
        day2_reg   <= day1_reg;
        ax2_reg    <= ax1_reg;
        ay2_reg    <= ay1_reg;
    end

    // ---- stage 3: cross sums ----
    logic                 v3_reg;
    logic signed [XW-1:0] c3_reg, tn3_reg, un3_reg;
    logic signed [DW-1:0] dax3_reg, day3_reg;
    logic signed [CB-1:0] ax3_reg, ay3_reg;

    always_ff @(posedge clk)
    begin
        c3_reg   <= XW'(p_adb_reg) - XW'(p_adbx_reg);
        tn3_reg  <= XW'(p_edb_reg) - XW'(p_edbx_reg);
        un3_reg  <= XW'(p_eda_reg) - XW'(p_edax_reg);
        dax3_reg <= dax2_reg;
        day3_reg <= day2_reg;
        ax3_reg  <= ax2_reg;
        ay3_reg  <= ay2_reg;
    end

    // ---- stage 4: fold the sign of c into tn and un ----
    logic                 v4_reg;
    logic                 par4_reg;
    logic signed [XW-1:0] c4_reg, tn4_reg, un4_reg;
    logic signed [DW-1:0] dax4_reg, day4_reg;
    logic signed [CB-1:0] ax4_reg, ay4_reg;

    always_ff @(posedge clk)
    begin
        par4_reg <= (c3_reg == '0);
        if (c3_reg[XW-1])
        begin
            c4_reg  <= -c3_reg;
            tn4_reg <= -tn3_reg;
            un4_reg <= -un3_reg;
        end
        else
        begin
            c4_reg  <= c3_reg;
            tn4_reg <= tn3_reg;
            un4_reg <= un3_reg;
        end
        dax4_reg <= dax3_reg;
        day4_reg <= day3_reg;
        ax4_reg  <= ax3_reg;
        ay4_reg  <= ay3_reg;
    end

    // ---- stage 5: range test ----
    logic                 v5_reg;
    logic                 hit5_reg, par5_reg;
    logic [NW-1:0]        num5_reg, den5_reg;
    logic signed [DW-1:0] dax5_reg, day5_reg;
    logic signed [CB-1:0] ax5_reg, ay5_reg;
    logic                 in_range;

    assign in_range = !par4_reg && !tn4_reg[XW-1] && !(tn4_reg > c4_reg)
                      && !un4_reg[XW-1] && !(un4_reg > c4_reg);

    always_ff @(posedge clk)
    begin
        hit5_reg <= in_range;
        par5_reg <= par4_reg;
        num5_reg <= in_range ? tn4_reg[NW-1:0] : '0;
        den5_reg <= c4_reg[NW-1:0];
        dax5_reg <= dax4_reg;
        day5_reg <= day4_reg;
        ax5_reg  <= ax4_reg;
        ay5_reg  <= ay4_reg;
    end

    // ---- divider ----
    logic                 vd;
    logic [TW-1:0]        tq;
    logic [SIDE_W-1:0]    side_in, side_out;
    logic                 hitd, pard;
    logic signed [DW-1:0] daxd, dayd;
    logic signed [CB-1:0] axd, ayd;

    assign side_in = {hit5_reg, par5_reg, dax5_reg, day5_reg, ax5_reg, ay5_reg};
    assign {hitd, pard, daxd, dayd, axd, ayd} = side_out;

    segx_frac_div #(
        .NUM_W     (NW),
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (SIDE_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v5_reg),
        .num       (num5_reg),
        .den       (den5_reg),
        .side_in   (side_in),
        .out_valid (vd),
        .quo       (tq),
        .side_out  (side_out)
    );

    // ---- point multiply ----
    logic                 vm_reg;
    logic                 hitm_reg, parm_reg;
    logic [TW-1:0]        tm_reg;
    logic signed [SW-1:0] prodx_reg, prody_reg;
    logic signed [CB-1:0] axm_reg, aym_reg;
    logic signed [TW:0]   tq_s;

    assign tq_s = {1'b0, tq};

    always_ff @(posedge clk)
    begin
        hitm_reg  <= hitd;
        parm_reg  <= pard;
        tm_reg    <= tq;
        prodx_reg <= SW'(daxd) * SW'(tq_s);
        prody_reg <= SW'(dayd) * SW'(tq_s);
        axm_reg   <= axd;
        aym_reg   <= ayd;
    end

    // ---- point add and output register ----
    logic signed [SW-1:0] sumx, sumy;
    logic signed [PT_W-1:0] px_next, py_next;

    assign sumx = {{3{axm_reg[CB-1]}}, axm_reg, {FRAC_BITS{1'b0}}} + prodx_reg;
    assign sumy = {{3{aym_reg[CB-1]}}, aym_reg, {FRAC_BITS{1'b0}}} + prody_reg;

    if (SW >= PT_W)
    begin : g_pt_wrap
        assign px_next = sumx[PT_W-1:0];
        assign py_next = sumy[PT_W-1:0];
    end
    else
    begin : g_pt_ext
        assign px_next = {{(PT_W-SW){sumx[SW-1]}}, sumx};
        assign py_next = {{(PT_W-SW){sumy[SW-1]}}, sumy};
    end

    logic                   done_reg, hit_reg, parallel_reg;
    logic [TW-1:0]          t_reg;
    logic signed [PT_W-1:0] px_reg, py_reg;

    always_ff @(posedge clk)
    begin
        hit_reg      <= hitm_reg;
        parallel_reg <= parm_reg;
        t_reg        <= hitm_reg ? tm_reg : '0;
        px_reg       <= hitm_reg ? px_next : '0;
        py_reg       <= hitm_reg ? py_next : '0;
    end

    // ---- valid bits ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            vm_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start && !busy;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            vm_reg   <= vd;
            done_reg <= vm_reg;
        end
    end

    assign done          = done_reg;
    assign hit           = hit_reg;
    assign parallel      = parallel_reg;
    assign param_along_a = t_reg;
    assign point_x       = px_reg;
    assign point_y       = py_reg;

endmodule

@@ rtl/segx_frac_div.sv @@
// ----------------------------------------------------------------------------
// segx_frac_div
// Pipelined restoring divider: floor(num * 2^FRAC_BITS / den) for
// num <= den, one quotient bit per stage, side data carried alongside.
// ----------------------------------------------------------------------------
module segx_frac_div
    import segx_pkg::*;
#(
    parameter int NUM_W     = 2 * COORD_BITS_DEF + 2,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int SIDE_W    = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [NUM_W-1:0]     num,
    input  logic [NUM_W-1:0]     den,
    input  logic [SIDE_W-1:0]    side_in,
    output logic                 out_valid,
    output logic [FRAC_BITS:0]   quo,
    output logic [SIDE_W-1:0]    side_out
);

    localparam int STAGES = FRAC_BITS + 1;

    logic                 valid_reg [0:STAGES-1];
    logic [NUM_W-1:0]     rem_reg   [0:STAGES-1];
    logic [NUM_W-1:0]     den_reg   [0:STAGES-1];
    logic [STAGES-1:0]    quo_reg   [0:STAGES-1];
    logic [SIDE_W-1:0]    side_reg  [0:STAGES-1];

    logic [NUM_W:0]       base      [0:STAGES-1];
    logic [NUM_W:0]       trial     [0:STAGES-1];
    logic [NUM_W-1:0]     den_cur   [0:STAGES-1];
    logic [STAGES-1:0]    quo_base  [0:STAGES-1];
    logic [SIDE_W-1:0]    side_cur  [0:STAGES-1];
    logic                 valid_cur [0:STAGES-1];
    logic                 ge        [0:STAGES-1];
    logic [NUM_W-1:0]     rem_next  [0:STAGES-1];
    logic [STAGES-1:0]    quo_next  [0:STAGES-1];

    // first stage yields the integer bit, the rest one fraction bit each
    always_comb
    begin
        for (int k = 0; k < STAGES; k++)
        begin
            if (k == 0)
            begin
                base[k]      = {1'b0, num};
                den_cur[k]   = den;
                quo_base[k]  = '0;
                side_cur[k]  = side_in;
                valid_cur[k] = in_valid;
            end
            else
            begin
                base[k]      = {rem_reg[k-1], 1'b0};
                den_cur[k]   = den_reg[k-1];
                quo_base[k]  = quo_reg[k-1];
                side_cur[k]  = side_reg[k-1];
                valid_cur[k] = valid_reg[k-1];
            end
            trial[k]    = base[k] - {1'b0, den_cur[k]};
            ge[k]       = !trial[k][NUM_W];
            rem_next[k] = ge[k] ? trial[k][NUM_W-1:0] : base[k][NUM_W-1:0];
            quo_next[k] = {quo_base[k][STAGES-2:0], ge[k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                valid_reg[k] <= valid_cur[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < STAGES; k++)
        begin
            rem_reg[k]  <= rem_next[k];
            den_reg[k]  <= den_cur[k];
            quo_reg[k]  <= quo_next[k];
            side_reg[k] <= side_cur[k];
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign quo       = quo_reg[STAGES-1];
    assign side_out  = side_reg[STAGES-1];

endmodule

@@ verif/tb_segment_intersection.sv @@
// ----------------------------------------------------------------------------
// tb_segment_intersection
// Self-checking bench for the segment intersection pipeline: directed
// corner cases, then random segment pairs (noise, small grids, pairs built
// to cross or touch), with random start gaps and a scoreboard that predicts
// hit, parallel, t and the crossing point for every word taken.
// ----------------------------------------------------------------------------
module tb_segment_intersection
    import segx_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC        = FRAC_BITS_DEF;
    localparam int PIPE_DEPTH  = FRAC_BITS_DEF + 8;
    localparam int IDLE_LIMIT  = 4000;
    localparam int RAND_WORDS  = 800;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic signed [IN_W-1:0] ax0;
        logic signed [IN_W-1:0] ay0;
        logic signed [IN_W-1:0] ax1;
        logic signed [IN_W-1:0] ay1;
        logic signed [IN_W-1:0] bx0;
        logic signed [IN_W-1:0] by0;
        logic signed [IN_W-1:0] bx1;
        logic signed [IN_W-1:0] by1;
    } seg_pair_t;

    typedef struct packed {
        logic            hit;
        logic            parallel;
        logic [FRAC:0]   t;
        logic [PT_W-1:0] px;
        logic [PT_W-1:0] py;
    } crossing_t;

    class segx_scoreboard;
        crossing_t crossings_due[$];
        int        mismatches;
        int        checked;
        int        hits;
        int        parallels;
        int        orphans;

        function crossing_t expected_crossing(seg_pair_t p);
            longint    dax, day, dbx, dby, ex, ey, cr, tn, un, tq, px, py;
            crossing_t r;
            r   = '0;
            dax = longint'(p.ax1) - longint'(p.ax0);
            day = longint'(p.ay1) - longint'(p.ay0);
            dbx = longint'(p.bx1) - longint'(p.bx0);
            dby = longint'(p.by1) - longint'(p.by0);
            ex  = longint'(p.bx0) - longint'(p.ax0);
            ey  = longint'(p.by0) - longint'(p.ay0);
            cr  = dax * dby - day * dbx;
            tn  = ex * dby - ey * dbx;
            un  = ex * day - ey * dax;
            if (cr == 0)
            begin
                r.parallel = 1'b1;
                return r;
            end
            // fold the sign so the range test is against a positive cross
            if (cr < 0)
            begin
                cr = -cr;
                tn = -tn;
                un = -un;
            end
            if (tn < 0 || tn > cr || un < 0 || un > cr)
                return r;
            tq    = (tn <<< FRAC) / cr;
            px    = longint'(p.ax0) * (longint'(1) <<< FRAC) + dax * tq;
            py    = longint'(p.ay0) * (longint'(1) <<< FRAC) + day * tq;
            r.hit = 1'b1;
            r.t   = tq[FRAC:0];
            r.px  = px[PT_W-1:0];
            r.py  = py[PT_W-1:0];
            return r;
        endfunction

        function void note_input(seg_pair_t p);
            crossings_due.push_back(expected_crossing(p));
        endfunction

        function void check_result(crossing_t got);
            crossing_t want;
            if (crossings_due.size() == 0)
            begin
                orphans++;
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result word with nothing outstanding", $realtime);
                return;
            end
            want = crossings_due.pop_front();
            checked++;
            if (got.hit)
                hits++;
            if (got.parallel)
                parallels++;
            if (got.hit != want.hit || got.parallel != want.parallel ||
                got.t != want.t || got.px != want.px || got.py != want.py)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: mismatch hit %0b/%0b par %0b/%0b t %h/%h x %h/%h y %h/%h",
                             $realtime, want.hit, got.hit, want.parallel, got.parallel,
                             want.t, got.t, want.px, got.px, want.py, got.py);
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic signed [IN_W-1:0] seg_a_start_x;
    logic signed [IN_W-1:0] seg_a_start_y;
    logic signed [IN_W-1:0] seg_a_end_x;
    logic signed [IN_W-1:0] seg_a_end_y;
    logic signed [IN_W-1:0] seg_b_start_x;
    logic signed [IN_W-1:0] seg_b_start_y;
    logic signed [IN_W-1:0] seg_b_end_x;
    logic signed [IN_W-1:0] seg_b_end_y;
    logic                   done;
    logic                   hit;
    logic                   parallel;
    logic [FRAC:0]          param_along_a;
    logic signed [PT_W-1:0] point_x;
    logic signed [PT_W-1:0] point_y;

    segx_scoreboard sb = new();
    int             idle_cycles;
    int             words_sent;

    segment_intersection DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .seg_a_start_x (seg_a_start_x),
        .seg_a_start_y (seg_a_start_y),
        .seg_a_end_x   (seg_a_end_x),
        .seg_a_end_y   (seg_a_end_y),
        .seg_b_start_x (seg_b_start_x),
        .seg_b_start_y (seg_b_start_y),
        .seg_b_end_x   (seg_b_end_x),
        .seg_b_end_y   (seg_b_end_y),
        .done          (done),
        .hit           (hit),
        .parallel      (parallel),
        .param_along_a (param_along_a),
        .point_x       (point_x),
        .point_y       (point_y)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // input and result sides both seen on the edge that takes the word
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_input('{seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
                                seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y});
            if (done)
                sb.check_result('{hit, parallel, param_along_a, point_x, point_y});
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $realtime, IDLE_LIMIT);
            $display("tb_segment_intersection: errors");
            $finish;
        end
    end

    function automatic seg_pair_t make_pair(int ax0, int ay0, int ax1, int ay1,
                                            int bx0, int by0, int bx1, int by1);
        seg_pair_t p;
        p.ax0 = IN_W'(ax0);
        p.ay0 = IN_W'(ay0);
        p.ax1 = IN_W'(ax1);
        p.ay1 = IN_W'(ay1);
        p.bx0 = IN_W'(bx0);
        p.by0 = IN_W'(by0);
        p.bx1 = IN_W'(bx1);
        p.by1 = IN_W'(by1);
        return p;
    endfunction

    function automatic int any_coord();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic int half_coord();
        return int'($urandom_range(0, 32766)) - 16383;
    endfunction

    function automatic int grid_coord();
        return int'($urandom_range(0, 16)) - 8;
    endfunction

    // B built through a point on A: an endpoint (t = 0 or 1) or the midpoint
    function automatic seg_pair_t crossing_pair();
        int ax0, ay0, ax1, ay1, mx, my, vx, vy, k;
        ax0 = half_coord();
        ay0 = half_coord();
        ax1 = half_coord();
        ay1 = half_coord();
        case ($urandom_range(0, 3))
            0:
            begin
                mx = ax0;
                my = ay0;
            end
            1:
            begin
                mx = ax1;
                my = ay1;
            end
            default:
            begin
                mx = (ax0 + ax1) / 2;
                my = (ay0 + ay1) / 2;
            end
        endcase
        vx = half_coord();
        vy = half_coord();
        k  = $urandom_range(0, 3);
        if ($urandom_range(0, 4) == 0)
            return make_pair(ax0, ay0, ax1, ay1, mx, my, mx - vx, my - vy);
        return make_pair(ax0, ay0, ax1, ay1, mx + vx, my + vy,
                         mx - (vx >>> k), my - (vy >>> k));
    endfunction

    function automatic seg_pair_t random_pair();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 25)
            return make_pair(any_coord(), any_coord(), any_coord(), any_coord(),
                             any_coord(), any_coord(), any_coord(), any_coord());
        if (sel < 50)
            return make_pair(grid_coord(), grid_coord(), grid_coord(), grid_coord(),
                             grid_coord(), grid_coord(), grid_coord(), grid_coord());
        return crossing_pair();
    endfunction

    task automatic send_pair(seg_pair_t p, int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start         <= 1'b1;
        seg_a_start_x <= p.ax0;
        seg_a_start_y <= p.ay0;
        seg_a_end_x   <= p.ax1;
        seg_a_end_y   <= p.ay1;
        seg_b_start_x <= p.bx0;
        seg_b_start_y <= p.by0;
        seg_b_end_x   <= p.bx1;
        seg_b_end_y   <= p.by1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        words_sent++;
    endtask

    function automatic int draw_gap(bit back_to_back);
        return back_to_back ? 0 : $urandom_range(0, 16);
    endfunction

    initial
    begin
        seg_pair_t directed[$];
        bit        burst;
        rst_n         = 1'b0;
        start         = 1'b0;
        seg_a_start_x = '0;
        seg_a_start_y = '0;
        seg_a_end_x   = '0;
        seg_a_end_y   = '0;
        seg_b_start_x = '0;
        seg_b_start_y = '0;
        seg_b_end_x   = '0;
        seg_b_end_y   = '0;
        words_sent    = 0;
        burst         = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // zero-length and all-equal segments are parallel
        directed.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_pair(32767, 32767, 32767, 32767,
                                     32767, 32767, 32767, 32767));
        directed.push_back(make_pair(-32768, -32768, -32768, -32768,
                                     -32768, -32768, -32768, -32768));
        directed.push_back(make_pair(-32768, -32768, 32767, 32767,
                                     -32768, 32767, 32767, -32768));
        directed.push_back(make_pair(32767, -32768, -32768, 32767,
                                     -32768, -32768, 32767, 32767));
        directed.push_back(make_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
        directed.push_back(make_pair(-32768, 32767, 32767, -32768, 0, -32768, 1, 32767));
        directed.push_back(make_pair(-32768, -32768, 32767, 32767,
                                     32767, 32767, 32767, -32768));
        directed.push_back(make_pair(0, 0, 10, 0, 5, 0, 15, 0));     // collinear overlap
        directed.push_back(make_pair(0, 0, 10, 0, 0, 5, 10, 5));     // parallel offset
        directed.push_back(make_pair(3, 3, 3, 3, 0, 0, 10, 10));     // A is a point
        directed.push_back(make_pair(0, 0, 10, 0, 20, -5, 20, 5));   // t above 1
        directed.push_back(make_pair(0, 0, 10, 0, -5, -5, -5, 5));   // t below 0
        directed.push_back(make_pair(0, 0, 10, 0, 5, 1, 5, 10));     // u out of range
        directed.push_back(make_pair(0, 0, 10, 0, 5, -10, 5, -1));   // u out, other side
        directed.push_back(make_pair(0, 0, 10, 0, 0, -5, 0, 5));     // t = 0
        directed.push_back(make_pair(0, 0, 10, 0, 10, -5, 10, 5));   // t = 1
        directed.push_back(make_pair(0, 0, 10, 0, 5, 0, 5, 7));      // u = 0
        directed.push_back(make_pair(0, 0, 10, 0, 5, -7, 5, 0));     // u = 1
        directed.push_back(make_pair(0, 0, 10, 0, 0, 0, 0, 10));     // shared start
        directed.push_back(make_pair(0, 0, 10, 0, 5, 5, 5, -5));     // negative cross
        directed.push_back(make_pair(0, 0, 3, 0, 1, -1, 1, 1));      // t = 1/3, truncated
        directed.push_back(make_pair(-7, 9, 2, -3, -9, -9, 9, 8));
        foreach (directed[i])
            send_pair(directed[i], draw_gap(i % 2 == 0));

        for (int n = 0; n < RAND_WORDS; n++)
        begin
            if ($urandom_range(0, 39) == 0)
                burst = ~burst;
            send_pair(random_pair(), draw_gap(burst));
        end
        start <= 1'b0;

        while (sb.crossings_due.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 8) @(posedge clk);

        $display("%0d segment pairs sent, %0d results checked", words_sent, sb.checked);
        $display("%0d crossings, %0d parallel or degenerate, %0d mismatches",
                 sb.hits, sb.parallels, sb.mismatches);
        if (sb.mismatches == 0 && sb.crossings_due.size() == 0)
            $display("tb_segment_intersection: clean");
        else
            $display("tb_segment_intersection: errors");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/segx_pkg.sv
rtl/segx_frac_div.sv
rtl/segment_intersection.sv
verif/tb_segment_intersection.sv
